// ===== design/bsmg_pkg.sv =====
// Shared types and constants for the bounded set min-gap/range block.
// No dependencies; imported by every module of the block.
package bsmg_pkg;

  localparam int VAL_W = 32;
  localparam int GAP_W = 33;
  localparam int CAP_W = 11;
  localparam int HC_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
  localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic [GAP_W-1:0] GAP_RESET = {GAP_W{1'b1}};

  // Status from the gap unit back to the sequencer.
  typedef struct packed {
    logic             busy;
    logic [GAP_W-1:0] min_gap;
  } gap_stat_t;

endpackage

// ===== design/bsmg_store.sv =====
// Value store: one write port, one read port, registered read data.
// Depends on bsmg_pkg for the value width.
module bsmg_store import bsmg_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0] rd_data,
  output logic                    rd_valid
);

  logic signed [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
    end
  end

endmodule

// ===== design/bsmg_gap.sv =====
// Gap unit: subtract, absolute value, then fold into the running minimum gap.
// Depends on bsmg_pkg for widths, reset value and the status struct.
module bsmg_gap import bsmg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [VAL_W-1:0] new_val,
  input  logic signed [VAL_W-1:0] old_val,
  input  logic                    old_valid,
  output gap_stat_t               stat
);

  logic signed [GAP_W-1:0] diff;
  logic                    diff_valid;
  logic [GAP_W-1:0]        mag;
  logic                    mag_valid;
  logic [GAP_W-1:0]        min_gap;

  always_ff @(posedge clk) begin
    diff <= {new_val[VAL_W-1], new_val} - {old_val[VAL_W-1], old_val};
    mag  <= diff[GAP_W-1] ? GAP_W'(-diff) : GAP_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      mag_valid  <= 1'b0;
      min_gap    <= GAP_RESET;
    end else begin
      diff_valid <= old_valid;
      mag_valid  <= diff_valid;
      if (mag_valid && (mag < min_gap)) begin
        min_gap <= mag;
      end
    end
  end

  assign stat.busy    = old_valid | diff_valid | mag_valid;
  assign stat.min_gap = min_gap;

endmodule

// ===== design/bounded_set_min_gap_and_range.sv =====
// Top level of the bounded set with minimum pairwise gap and value range.
// Depends on bsmg_pkg, bsmg_store and bsmg_gap.
//
//  channel  | signals                                   | direction | handshake
//  ---------+-------------------------------------------+-----------+-------------------
//  command  | start, busy, value                        | in        | start & !busy
//  result   | done, add_status, held_count, span_valid, | out       | done, one cycle,
//           | shortest_span, longest_span               |           | cannot be held off
//  config   | cfg_valid, cfg_ready, cfg_data            | in        | cfg_valid & cfg_ready
//
// Sequence: for a stored value with N values already held, the scan makes one
// store read per held value, the gap pipeline drains, the update state commits
// it and the done strobe follows; a rejected value or the first value goes
// straight to the update state. The single read port of the value store sets
// the scan length. busy stays high until the update cycle ends; a new
// command may be issued in the cycle done is high. Reset (rst, synchronous)
// empties the set, restores capacity to 1024 and needs no clearing pass.
module bounded_set_min_gap_and_range import bsmg_pkg::*; #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CAP_W-1:0]        cfg_data,
  output logic                    done,
  output logic                    add_status,
  output logic [HC_W-1:0]         held_count,
  output logic                    span_valid,
  output logic [VAL_W-1:0]        shortest_span,
  output logic [VAL_W-1:0]        longest_span
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [CAP_W-1:0]        capacity;
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic signed [VAL_W-1:0] new_val;
  logic signed [VAL_W-1:0] min_val;
  logic signed [VAL_W-1:0] max_val;
  logic                    rejected;
  logic [31:0]             limit;
  logic                    full;
  logic                    rd_en;
  logic                    wr_en;
  logic signed [VAL_W-1:0] rd_data;
  logic                    rd_valid;
  gap_stat_t               gap_stat;
  logic signed [GAP_W-1:0] range;

  // Saturate the configured capacity at the store depth.
  assign limit = (32'(capacity) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : 32'(capacity);
  assign full  = 32'(count) >= limit;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign rd_en     = (state == ST_SCAN);
  assign wr_en     = (state == ST_UPDATE) && !rejected;

  bsmg_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (count[AW-1:0]),
    .wr_data  (new_val),
    .rd_en    (rd_en),
    .rd_addr  (idx[AW-1:0]),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  bsmg_gap u_gap (
    .clk       (clk),
    .rst       (rst),
    .new_val   (new_val),
    .old_val   (rd_data),
    .old_valid (rd_valid),
    .stat      (gap_stat)
  );

  // Sequencer: scan every held entry, let the gap pipeline drain, then update; a full or empty set skips the scan.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (full || (count == '0)) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if ((idx + 1'b1) == count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!gap_stat.busy) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= CAP_RESET;
      count    <= '0;
      idx      <= '0;
      min_val  <= INT_MAX;
      max_val  <= INT_MIN;
      rejected <= 1'b0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_UPDATE);
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      // Latch the command transaction; decide rejection against the current fill.
      if ((state == ST_IDLE) && start) begin
        rejected <= full;
        idx      <= '0;
      end
      if (state == ST_SCAN) begin
        idx <= idx + 1'b1;
      end
      // Commit a stored value: advance the fill and widen the range.
      if (wr_en) begin
        count <= count + 1'b1;
        if (new_val < min_val) begin
          min_val <= new_val;
        end
        if (new_val > max_val) begin
          max_val <= new_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      new_val <= value;
    end
  end

  // Result fields follow the committed state; they are sampled with done.
  assign range         = {max_val[VAL_W-1], max_val} - {min_val[VAL_W-1], min_val};
  assign add_status    = rejected;
  assign held_count    = HC_W'(count);
  assign span_valid    = (count >= CW'(2));
  assign shortest_span = span_valid ? gap_stat.min_gap[VAL_W-1:0] : '0;
  assign longest_span  = span_valid ? range[VAL_W-1:0] : '0;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("result strobe outside idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_ENTRIES))
    else $error("fill count above store depth");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (idx < count))
    else $error("read of an entry that was never written");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> !gap_stat.busy)
    else $error("commit while gap pipeline still busy");
`endif

endmodule

// ===== dv/tb_bounded_set_min_gap_and_range.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bounded_set_min_gap_and_range: a queued command driver,
// a result monitor with its own model of the set, and a capacity register driver.
// Depends on bsmg_pkg and the block's RTL only.
module tb_bounded_set_min_gap_and_range;
  import bsmg_pkg::*;

  localparam int MAX_ENTRIES = 1024;
  // Quiet cycles required before a capacity write; the block holds busy until its
  // update cycle ends.
  localparam int SETTLE = 6;
  // Slowest run: about 550 adds, each scanning up to 1024 entries, plus idle
  // bursts; the limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef enum logic [1:0] {JOB_ADD, JOB_CAP, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e        kind;
    logic [VAL_W-1:0] value;
    logic [CAP_W-1:0] cap;
    bit               may_idle;
  } job_t;

  typedef struct packed {
    logic             rejected;
    logic [HC_W-1:0]  count;
    logic             valid;
    logic [VAL_W-1:0] shortest;
    logic [VAL_W-1:0] longest;
  } set_report_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] value = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CAP_W-1:0]        cfg_data = '0;
  logic                    done;
  logic                    add_status;
  logic [HC_W-1:0]         held_count;
  logic                    span_valid;
  logic [VAL_W-1:0]        shortest_span;
  logic [VAL_W-1:0]        longest_span;

  bounded_set_min_gap_and_range #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .add_status   (add_status),
    .held_count   (held_count),
    .span_valid   (span_valid),
    .shortest_span(shortest_span),
    .longest_span (longest_span)
  );

  always #10 clk = ~clk;

  // Work for the driver, filled up front by the stimulus block.
  job_t pending_jobs[$];
  // Reports the block owes us, oldest first.
  set_report_t set_reports_due[$];

  // Model of the set, updated at each accepted transaction.
  logic [VAL_W-1:0]        model_vals [MAX_ENTRIES];
  int unsigned             model_count;
  logic signed [VAL_W-1:0] model_low;
  logic signed [VAL_W-1:0] model_high;
  logic [GAP_W-1:0]        model_gap;
  logic [CAP_W-1:0]        model_cap;

  // What the stimulus block expects the set to hold; needed to aim values at stored ones.
  logic [VAL_W-1:0] plan_vals[$];
  int unsigned      plan_count;
  int unsigned      plan_cap;

  int unsigned mismatches;
  int unsigned hold_off;
  int unsigned quiet_run;
  int unsigned cycle_count;

  // Absolute difference of two signed words, formed at 33 bits.
  function automatic logic [GAP_W-1:0] abs_gap(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic signed [GAP_W-1:0] d;
    d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
    return (d < 0) ? -d : d;
  endfunction

  // Offer one value to the model set and return the report the block must give.
  function automatic set_report_t admit_value(logic [VAL_W-1:0] v);
    set_report_t r;
    int unsigned limit;
    logic [GAP_W-1:0] g;
    limit = (model_cap > MAX_ENTRIES) ? MAX_ENTRIES : model_cap;
    r.rejected = (model_count >= limit);
    if (!r.rejected) begin
      // Compare against every value already held, then store.
      for (int i = 0; i < model_count; i++) begin
        g = abs_gap(v, model_vals[i]);
        if (g < model_gap) model_gap = g;
      end
      model_vals[model_count] = v;
      model_count++;
      if ($signed(v) < model_low) model_low = v;
      if ($signed(v) > model_high) model_high = v;
    end
    r.count = model_count[HC_W-1:0];
    r.valid = (model_count >= 2);
    if (r.valid) begin
      r.shortest = model_gap[VAL_W-1:0];
      g = abs_gap(model_high, model_low);
      r.longest = g[VAL_W-1:0];
    end else begin
      r.shortest = '0;
      r.longest = '0;
    end
    return r;
  endfunction

  // Mix of wide random values, extremes, near neighbors of held values, and rare duplicates.
  function automatic logic [VAL_W-1:0] draw_value();
    int unsigned pick;
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] delta;
    pick = $urandom_range(0, 99);
    if (pick < 40 || plan_vals.size() == 0) return $urandom();
    if (pick < 50) begin
      case ($urandom_range(0, 4))
        0: return INT_MIN;
        1: return INT_MAX;
        2: return '0;
        3: return '1;
        default: return 32'd1;
      endcase
    end
    base = plan_vals[$urandom_range(0, plan_vals.size() - 1)];
    // Duplicates drive the gap to zero for good, so keep them late and rare.
    if (pick < 52 && plan_vals.size() > 200) return base;
    delta = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? base + delta : base - delta;
  endfunction

  task automatic append_job(job_t j);
    pending_jobs = {pending_jobs, j};
  endtask

  task automatic queue_add(logic [VAL_W-1:0] v, bit calm);
    append_job('{JOB_ADD, v, '0, !calm});
    if (plan_count < ((plan_cap > MAX_ENTRIES) ? MAX_ENTRIES : plan_cap)) begin
      plan_vals = {plan_vals, v};
      plan_count++;
    end
  endtask

  task automatic queue_cap(int unsigned c);
    append_job('{JOB_CAP, '0, c[CAP_W-1:0], 1'b0});
    plan_cap = c;
  endtask

  task automatic queue_drain();
    append_job('{JOB_DRAIN, '0, '0, 1'b0});
  endtask

  // Driver: present one job at a time. Hold start until accepted, hold the capacity
  // write until the block is quiet, and insert random idle bursts between adds.
  always @(posedge clk) begin : drive
    logic go_start;
    logic go_cfg;
    job_t job;
    go_start = start;
    go_cfg = cfg_valid;
    if (rst) begin
      go_start = 1'b0;
      go_cfg = 1'b0;
      hold_off = 0;
      quiet_run = 0;
    end else begin
      if (start && !busy) go_start = 1'b0;
      if (cfg_valid && cfg_ready) go_cfg = 1'b0;
      quiet_run = (set_reports_due.size() == 0 && !busy && !start) ? quiet_run + 1 : 0;
      if (!go_start && !go_cfg) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (pending_jobs.size() > 0) begin
          job = pending_jobs[0];
          case (job.kind)
            JOB_ADD: begin
              if (job.may_idle && $urandom_range(0, 5) == 0) begin
                hold_off = $urandom_range(1, 12);
              end else begin
                go_start = 1'b1;
                value <= job.value;
                void'(pending_jobs.pop_front());
              end
            end
            JOB_CAP: begin
              // Write only once every report is in and the block has settled.
              if (quiet_run >= SETTLE) begin
                go_cfg = 1'b1;
                cfg_data <= job.cap;
                void'(pending_jobs.pop_front());
              end
            end
            default: begin
              // Stall the sender until nothing is owed.
              if (quiet_run >= 2) void'(pending_jobs.pop_front());
            end
          endcase
        end
      end
    end
    start <= go_start;
    cfg_valid <= go_cfg;
  end

  // Monitor: check each result against the oldest owed report, then record
  // capacity writes and accepted transactions in the model.
  always @(posedge clk) begin : watch
    set_report_t got;
    set_report_t want;
    if (rst) begin
      model_count = 0;
      model_low = INT_MAX;
      model_high = INT_MIN;
      model_gap = GAP_RESET;
      model_cap = CAP_RESET;
      set_reports_due.delete();
    end else begin
      if (done) begin
        got = '{add_status, held_count, span_valid, shortest_span, longest_span};
        if (set_reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status=%0d count=%0d valid=%0d short=%h long=%h",
                     got.rejected, got.count, got.valid, got.shortest, got.longest);
        end else begin
          want = set_reports_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: want status=%0d count=%0d valid=%0d short=%h long=%h",
                       want.rejected, want.count, want.valid, want.shortest, want.longest);
              $display("          got  status=%0d count=%0d valid=%0d short=%h long=%h",
                       got.rejected, got.count, got.valid, got.shortest, got.longest);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) model_cap = cfg_data;
      if (start && !busy) set_reports_due = {set_reports_due, admit_value(value)};
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned rand_adds;
    int unsigned new_cap;
    int unsigned burst;
    int unsigned close_cap;
    mismatches = 0;
    cycle_count = 0;
    plan_count = 0;
    plan_cap = CAP_RESET;
    rand_adds = 0;

    // Directed: zero capacity rejects everything, even on an empty set.
    queue_cap(0);
    queue_add(INT_MIN, 0);
    queue_add(INT_MAX, 0);
    queue_add('0, 0);
    // One value held: still no spans.
    queue_cap(1);
    queue_add(INT_MIN, 0);
    queue_add(INT_MAX, 0);
    // Both extremes held: gap and range are at their widest.
    queue_cap(2);
    queue_add(INT_MAX, 0);
    queue_add(INT_MAX, 0);
    queue_drain();
    // Capacity above the store size saturates; the set keeps growing.
    queue_cap(2047);
    queue_add('0, 0);
    queue_add(32'h4000_0000, 0);
    queue_add(32'hC000_0001, 0);
    // Capacity below the held count rejects without touching the set.
    queue_cap(3);
    queue_add(32'h1234_5678, 0);
    queue_add('1, 0);

    // Random phases: a capacity write, then a burst of adds.
    while (rand_adds < 440) begin
      case ($urandom_range(0, 9))
        0: new_cap = 0;
        1: new_cap = $urandom_range(0, plan_count);
        2: new_cap = MAX_ENTRIES;
        3: new_cap = 2047;
        default: new_cap = plan_count + $urandom_range(1, 30);
      endcase
      queue_cap(new_cap);
      burst = $urandom_range(5, 60);
      repeat (burst) begin
        if ($urandom_range(0, 39) == 0) queue_drain();
        queue_add(draw_value(), 0);
        rand_adds++;
      end
    end

    // Closing stretch without idling: fill up to a fresh capacity, then overflow it.
    close_cap = plan_count + 40;
    if (close_cap > MAX_ENTRIES) close_cap = MAX_ENTRIES;
    queue_cap(close_cap);
    while (plan_count < close_cap) queue_add(draw_value(), 1);
    queue_add(INT_MAX, 1);
    queue_add(INT_MIN, 1);
    queue_cap(MAX_ENTRIES);
    queue_add('0, 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (pending_jobs.size() != 0 || start || cfg_valid);
    do @(posedge clk); while (set_reports_due.size() != 0);
    // Let any stray result show up before the verdict.
    repeat (12) @(posedge clk);
    if (mismatches == 0 && set_reports_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== bounded_set_min_gap_and_range.f =====
design/bsmg_pkg.sv
design/bsmg_store.sv
design/bsmg_gap.sv
design/bounded_set_min_gap_and_range.sv
dv/tb_bounded_set_min_gap_and_range.sv
